// File: hdl/stxf_pkg.sv
// Shared constants, types and the line byte builder for the STX framer.
// Used by stx_escape_checksum_framer; no dependencies.
`default_nettype none

package stxf_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned MaxLine  = 5;
    localparam int unsigned CntW     = $clog2(MaxLine + 1);

    localparam logic [ByteW-1:0] START_BYTE  = 8'h02;
    localparam logic [ByteW-1:0] ESCAPE_BYTE = 8'h1B;
    localparam logic [ByteW-1:0] SUM_SEED    = 8'h55;
    // Checksum value right after the start byte went out
    localparam logic [ByteW-1:0] SUM_START   = SUM_SEED + START_BYTE;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [CntW-1:0]  cnt_t;

    // Line bytes caused by one request, lowest slot goes out first
    typedef struct packed {
        byte_t [MaxLine-1:0] bytes;
        cnt_t                cnt;
    } line_seq_t;

    function automatic logic needs_escape(input byte_t b);
        needs_escape = (b == START_BYTE) || (b == ESCAPE_BYTE);
    endfunction

    // Start byte (optional), stuffed data byte, stuffed checksum (optional)
    function automatic line_seq_t build_seq(input byte_t data, input logic first,
                                            input logic last, input byte_t sum);
        line_seq_t seq;
        cnt_t      idx;
        seq = '0;
        idx = '0;
        if (first) begin
            seq.bytes[idx] = START_BYTE;
            idx = idx + cnt_t'(1);
        end
        if (needs_escape(data)) begin
            seq.bytes[idx] = ESCAPE_BYTE;
            idx = idx + cnt_t'(1);
            seq.bytes[idx] = ~data;
        end else begin
            seq.bytes[idx] = data;
        end
        idx = idx + cnt_t'(1);
        if (last) begin
            if (needs_escape(sum)) begin
                seq.bytes[idx] = ESCAPE_BYTE;
                idx = idx + cnt_t'(1);
                seq.bytes[idx] = ~sum;
            end else begin
                seq.bytes[idx] = sum;
            end
            idx = idx + cnt_t'(1);
        end
        seq.cnt = idx;
        return seq;
    endfunction

endpackage

`default_nettype wire

// File: hdl/stx_escape_checksum_framer.sv
// Transmit framer: start byte, byte stuffing and additive checksum on a byte stream.
// Depends on stxf_pkg for constants and the line byte builder.
`default_nettype none

// One input request (a raw telegram byte) expands to one to five line bytes:
// an optional start byte 0x02 when s_tuser (first byte) is set, the data byte
// stuffed (0x02 and 0x1B go out as 0x1B plus the inverted byte), and after a
// byte with s_tlast set the 8-bit additive checksum, stuffed the same way.
// The checksum is reseeded to 0x57 on each first byte and otherwise keeps
// running. Line bytes leave at one per cycle through an output register while
// m_tready does not stall them; a request is accepted while no line byte is
// pending or in the cycle the previous request's last line byte moves to that
// register. Its line bytes are held in a pending register, then the output register.
// m_tuser marks the last line byte of each request, m_tlast the final
// checksum byte of a telegram.
module stx_escape_checksum_framer
    import stxf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // input stream
    input  wire logic             s_tvalid,
    output      logic             s_tready,
    input  wire logic [ByteW-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic             s_tlast,   // last_byte
    input  wire logic             s_tuser,   // [0] first_byte
    // line stream
    output      logic             m_tvalid,
    input  wire logic             m_tready,
    output      logic [ByteW-1:0] m_tdata,   // [7:0] line_byte
    output      logic             m_tlast,   // frame_end
    output      logic             m_tuser    // [0] run_end
);

    byte_t               sum_reg, sum_next;
    byte_t [MaxLine-1:0] seq_byte_reg, seq_byte_next;
    cnt_t                seq_cnt_reg, seq_cnt_next;
    logic                seq_frame_reg, seq_frame_next;
    logic                m_valid_reg, m_valid_next;
    byte_t               m_byte_reg, m_byte_next;
    logic                m_run_reg, m_run_next;
    logic                m_frame_reg, m_frame_next;

    line_seq_t           new_seq;
    logic                out_free;
    logic                move;
    logic                accept;
    logic                seq_last;

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign seq_last = (seq_cnt_reg == cnt_t'(1));
    assign move     = (seq_cnt_reg != '0) && out_free;
    assign s_tready = (seq_cnt_reg == '0) || (seq_last && out_free);
    assign accept   = s_tvalid && s_tready;

    // checksum update and line byte sequence for the incoming request
    always_comb begin
        sum_next = sum_reg;
        if (accept) begin
            sum_next = (s_tuser ? SUM_START : sum_reg) + s_tdata;
        end
        new_seq = build_seq(s_tdata, s_tuser, s_tlast, sum_next);
    end

    // pending line bytes: load on accept, else shift out one per move
    always_comb begin
        seq_byte_next  = seq_byte_reg;
        seq_cnt_next   = seq_cnt_reg;
        seq_frame_next = seq_frame_reg;
        if (accept) begin
            seq_byte_next  = new_seq.bytes;
            seq_cnt_next   = new_seq.cnt;
            seq_frame_next = s_tlast;
        end else if (move) begin
            for (int i = 0; i < MaxLine - 1; i++) begin
                seq_byte_next[i] = seq_byte_reg[i+1];
            end
            seq_byte_next[MaxLine-1] = '0;
            seq_cnt_next = seq_cnt_reg - cnt_t'(1);
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_run_next   = m_run_reg;
        m_frame_next = m_frame_reg;
        if (move) begin
            m_valid_next = 1'b1;
            m_byte_next  = seq_byte_reg[0];
            m_run_next   = seq_last;
            m_frame_next = seq_last && seq_frame_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= SUM_SEED;
            seq_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            seq_cnt_reg <= seq_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        seq_byte_reg  <= seq_byte_next;
        seq_frame_reg <= seq_frame_next;
        m_byte_reg    <= m_byte_next;
        m_run_reg     <= m_run_next;
        m_frame_reg   <= m_frame_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_frame_reg;
    assign m_tuser  = m_run_reg;

endmodule

`default_nettype wire
